// ===== src/pfde_pkg.sv =====
// Shared types, constants and codes for the page frame store draw engine.
package pfde_pkg;

    localparam int PAGE_COUNT_DEF   = 8;
    localparam int COLUMN_COUNT_DEF = 128;

    localparam int ACTION_W      = 3;
    localparam int COLUMN_W      = 7;
    localparam int PIXEL_ROW_W   = 6;
    localparam int FIELD_VALUE_W = 8;
    localparam int BIT_COUNT_W   = 4;
    localparam int PAGE_W        = 3;
    localparam int BYTE_W        = 8;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_INVERSE_MODE = 1'b0;

    localparam logic [BIT_COUNT_W-1:0] MAX_BIT_COUNT = 4'd8;
    localparam logic [BYTE_W-1:0]      BYTE_ONES     = 8'hFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PIXEL = 3'd0,
        ACT_FIELD = 3'd1,
        ACT_LINE  = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_READ  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_HIGH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic inc;
        logic step_hi;
        logic wr;
        logic init;
        logic hi;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic at_end;
        logic hi_need;
        logic out_free;
    } status_t;

endpackage

// ===== src/pfde_ctrl.sv =====
// Control state machine: reset clearing pass, item acceptance, byte walk and result hand-off.
module pfde_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfde_pkg::status_t st,
    output pfde_pkg::cmd_t    cmd
);
    import pfde_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init = 1'b1;
                cmd.wr   = 1'b1;
                if (st.init_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.wr = 1'b1;
                if (!st.at_end)
                begin
                    cmd.inc = 1'b1;
                end
                else if (st.hi_need)
                begin
                    cmd.step_hi = 1'b1;
                    state_next  = ST_HIGH;
                end
                else if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_HIGH:
            begin
                cmd.wr = 1'b1;
                cmd.hi = 1'b1;
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== src/pfde_datapath.sv =====
// Datapath: command decode, address walker, frame store memory, byte merge and result register.
module pfde_datapath #(
    parameter int PAGE_COUNT   = pfde_pkg::PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = pfde_pkg::COLUMN_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pfde_pkg::cmd_t                        cmd,
    output pfde_pkg::status_t                     st,
    input  logic                                  inverse_mode,
    input  logic [pfde_pkg::ACTION_W-1:0]         action,
    input  logic [pfde_pkg::COLUMN_W-1:0]         column,
    input  logic [pfde_pkg::PIXEL_ROW_W-1:0]      pixel_row,
    input  logic                                  pixel_on,
    input  logic [pfde_pkg::FIELD_VALUE_W-1:0]    field_value,
    input  logic [pfde_pkg::BIT_COUNT_W-1:0]      bit_count,
    input  logic [pfde_pkg::PAGE_W-1:0]           first_page,
    input  logic [pfde_pkg::PAGE_W-1:0]           last_page,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pfde_pkg::BYTE_W-1:0]           read_byte,
    output logic                                  range_empty
);
    import pfde_pkg::*;

    localparam int DEPTH  = PAGE_COUNT * COLUMN_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WIDE_W = $clog2(COLUMN_COUNT) + 5;

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] end_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic [BYTE_W-1:0] mask_lo_reg;
    logic [BYTE_W-1:0] bits_lo_reg;
    logic [BYTE_W-1:0] mask_hi_reg;
    logic [BYTE_W-1:0] bits_hi_reg;
    logic              wr_ok_reg;
    logic              hi_ok_reg;
    logic              rd_ok_reg;
    logic              empty_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] read_byte_reg;
    logic              range_empty_reg;

    // decode of the incoming item
    logic [WIDE_W-1:0]      page_w;
    logic [WIDE_W-1:0]      col_w;
    logic [WIDE_W-1:0]      first_w;
    logic [WIDE_W-1:0]      last_w;
    logic [WIDE_W-1:0]      last_c;
    logic [WIDE_W-1:0]      base;
    logic [WIDE_W-1:0]      index_w;
    logic [WIDE_W-1:0]      start_w;
    logic [WIDE_W-1:0]      stop_w;
    logic [2:0]             rem;
    logic                   page_ok;
    logic                   col_ok;
    logic [BIT_COUNT_W-1:0] cnt;
    logic [2*BYTE_W-1:0]    field_mask;
    logic [2*BYTE_W-1:0]    field_bits;
    logic [BYTE_W-1:0]      pix_mask;
    logic [BYTE_W-1:0]      mask_lo_next;
    logic [BYTE_W-1:0]      bits_lo_next;
    logic                   wr_ok_next;
    logic                   hi_ok_next;
    logic                   rd_ok_next;
    logic                   empty_next;

    logic              mem_we;
    logic [BYTE_W-1:0] wmask;
    logic [BYTE_W-1:0] wbits;
    logic [BYTE_W-1:0] wdata;

    always_comb
    begin
        page_w     = WIDE_W'(pixel_row[PIXEL_ROW_W-1:3]);
        rem        = pixel_row[2:0];
        col_w      = WIDE_W'(column);
        first_w    = WIDE_W'(first_page);
        last_w     = WIDE_W'(last_page);
        page_ok    = page_w < WIDE_W'(PAGE_COUNT);
        col_ok     = col_w < WIDE_W'(COLUMN_COUNT);
        last_c     = (last_w < WIDE_W'(PAGE_COUNT)) ? last_w : WIDE_W'(PAGE_COUNT - 1);
        cnt        = (bit_count > MAX_BIT_COUNT) ? MAX_BIT_COUNT : bit_count;
        field_mask = ((16'd1 << cnt) - 16'd1) << rem;
        field_bits = ({8'd0, field_value} << rem) & field_mask;
        pix_mask   = 8'd1 << rem;
        base       = page_w * WIDE_W'(COLUMN_COUNT);
        index_w    = base + col_w;

        mask_lo_next = BYTE_ONES;
        bits_lo_next = '0;
        wr_ok_next   = 1'b0;
        hi_ok_next   = 1'b0;
        rd_ok_next   = 1'b0;
        empty_next   = 1'b0;
        start_w      = index_w;
        stop_w       = index_w;
        case (action_t'(action))
            ACT_PIXEL:
            begin
                mask_lo_next = pix_mask;
                bits_lo_next = (pixel_on ^ inverse_mode) ? BYTE_ONES : '0;
                wr_ok_next   = page_ok && col_ok;
            end
            ACT_FIELD:
            begin
                mask_lo_next = field_mask[BYTE_W-1:0];
                bits_lo_next = field_bits[BYTE_W-1:0];
                wr_ok_next   = page_ok && col_ok;
                hi_ok_next   = col_ok && ((page_w + 1'b1) < WIDE_W'(PAGE_COUNT))
                               && (field_mask[2*BYTE_W-1:BYTE_W] != '0);
            end
            ACT_LINE:
            begin
                mask_lo_next = pix_mask;
                bits_lo_next = BYTE_ONES;
                wr_ok_next   = page_ok;
                start_w      = base;
                stop_w       = base + WIDE_W'(COLUMN_COUNT - 1);
            end
            ACT_CLEAR:
            begin
                empty_next = last_page < first_page;
                wr_ok_next = !empty_next && (first_w < WIDE_W'(PAGE_COUNT));
                start_w    = first_w * WIDE_W'(COLUMN_COUNT);
                stop_w     = (last_c + 1'b1) * WIDE_W'(COLUMN_COUNT) - 1'b1;
            end
            ACT_READ:
            begin
                rd_ok_next = page_ok && col_ok;
            end
            default:
            begin
                wr_ok_next = 1'b0;
            end
        endcase
        if (!wr_ok_next)
        begin
            stop_w = start_w;
        end
    end

    always_comb
    begin
        if (cmd.load)
        begin
            addr_next = ADDR_W'(start_w);
        end
        else if (cmd.step_hi)
        begin
            addr_next = addr_reg + ADDR_W'(COLUMN_COUNT);
        end
        else if (cmd.inc)
        begin
            addr_next = addr_reg + 1'b1;
        end
        else
        begin
            addr_next = addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            end_reg     <= ADDR_W'(stop_w);
            mask_lo_reg <= mask_lo_next;
            bits_lo_reg <= bits_lo_next;
            mask_hi_reg <= field_mask[2*BYTE_W-1:BYTE_W];
            bits_hi_reg <= field_bits[2*BYTE_W-1:BYTE_W];
            wr_ok_reg   <= wr_ok_next;
            hi_ok_reg   <= hi_ok_next;
            rd_ok_reg   <= rd_ok_next;
            empty_reg   <= empty_next;
        end
    end

    // read of the next byte overlaps the write of the current one
    always_comb
    begin
        wmask  = cmd.hi ? mask_hi_reg : mask_lo_reg;
        wbits  = cmd.hi ? bits_hi_reg : bits_lo_reg;
        wdata  = cmd.init ? '0 : ((rdata_reg & ~wmask) | (wbits & wmask));
        mem_we = cmd.wr && (cmd.init || cmd.hi || wr_ok_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.inc || cmd.step_hi)
        begin
            rdata_reg <= mem[addr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_byte_reg   <= rd_ok_reg ? rdata_reg : '0;
            range_empty_reg <= empty_reg;
        end
    end

    assign st.init_last = addr_reg == ADDR_W'(DEPTH - 1);
    assign st.at_end    = addr_reg == end_reg;
    assign st.hi_need   = hi_ok_reg;
    assign st.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign read_byte   = read_byte_reg;
    assign range_empty = range_empty_reg;

endmodule

// ===== src/page_framebuffer_draw_engine_core.sv =====
// Top level of the page frame store draw engine: stream ports, register port, core wiring.
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | tvalid / tready              | one draw, clear or read command
//  m_axis    | out       | tvalid / tready              | read_byte, range_empty
//  apb       | in/out    | psel, penable, pwrite, pready| inverse_mode at offset 0
//
// Pixel, field and read commands each visit one byte; a field crossing into the next page
// also writes the byte below it. Line walks the COLUMN_COUNT bytes of its page; clear walks
// the named pages, one byte per cycle through the single write port of the frame store.
// After reset all PAGE_COUNT * COLUMN_COUNT bytes are zeroed with s_axis_tready low.
// A finished result sits in the output register while the next command is taken; a command
// that completes while that register is still full holds until it is transferred.
module page_framebuffer_draw_engine_core #(
    parameter int PAGE_COUNT   = pfde_pkg::PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = pfde_pkg::COLUMN_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action[2:0], column[9:3], pixel_row[15:10], pixel_on[16], field_value[24:17],
    // bit_count[28:25], first_page[31:29], last_page[34:32], zero[39:35]
    input  logic [pfde_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_byte[7:0], range_empty[8], zero[15:9]
    output logic [pfde_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfde_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pfde_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pfde_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pfde_pkg::*;

    logic              inverse_mode_reg;
    logic              reg_hit;
    cmd_t              cmd;
    status_t           st;
    logic [BYTE_W-1:0] read_byte;
    logic              range_empty;

    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_INVERSE_MODE;
    assign prdata  = reg_hit ? APB_DATA_W'(inverse_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            inverse_mode_reg <= pwdata[0];
        end
    end

    pfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pfde_datapath #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .inverse_mode (inverse_mode_reg),
        .action       (s_axis_tdata[2:0]),
        .column       (s_axis_tdata[9:3]),
        .pixel_row    (s_axis_tdata[15:10]),
        .pixel_on     (s_axis_tdata[16]),
        .field_value  (s_axis_tdata[24:17]),
        .bit_count    (s_axis_tdata[28:25]),
        .first_page   (s_axis_tdata[31:29]),
        .last_page    (s_axis_tdata[34:32]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .read_byte    (read_byte),
        .range_empty  (range_empty)
    );

    assign m_axis_tdata = {7'd0, range_empty, read_byte};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the page frame store draw engine: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
    import pfde_pkg::*;

    localparam int PAGES = PAGE_COUNT_DEF;
    localparam int COLS  = COLUMN_COUNT_DEF;

    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 5;

    localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [COLUMN_W-1:0]      column;
        logic [PIXEL_ROW_W-1:0]   pixel_row;
        logic                     pixel_on;
        logic [FIELD_VALUE_W-1:0] field_value;
        logic [BIT_COUNT_W-1:0]   bit_count;
        logic [PAGE_W-1:0]        first_page;
        logic [PAGE_W-1:0]        last_page;
    } draw_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              range_empty;
    } reply_t;

    typedef struct packed {
        draw_cmd_t cmd;
        logic      typed;
        reply_t    want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 26;

    // typed = 1: reply is fixed by the row; otherwise it comes from the frame shadow
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{ACT_READ,    7'd0,   6'd0,  1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_PIXEL,   7'd0,   6'd0,  1'b1, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd0,   6'd0,  1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h01, 1'b0}},
        '{'{ACT_PIXEL,   7'd127, 6'd63, 1'b1, 8'hFF, 4'd15, 3'd7, 3'd7}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd127, 6'd63, 1'b1, 8'hFF, 4'd15, 3'd7, 3'd7}, 1'b1, '{8'h80, 1'b0}},
        '{'{ACT_PIXEL,   7'd127, 6'd63, 1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd127, 6'd56, 1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_FIELD,   7'd5,   6'd0,  1'b0, 8'hFF, 4'd8,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd5,   6'd0,  1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'hFF, 1'b0}},
        // field crossing into the next page
        '{'{ACT_FIELD,   7'd6,   6'd13, 1'b0, 8'hAA, 4'd8,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd6,   6'd8,  1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b0, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd6,   6'd16, 1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b0, '{8'h00, 1'b0}},
        // value bits above the count are masked
        '{'{ACT_FIELD,   7'd7,   6'd10, 1'b0, 8'hFF, 4'd3,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd7,   6'd8,  1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b0, '{8'h00, 1'b0}},
        // spill past the bottom page is dropped
        '{'{ACT_FIELD,   7'd8,   6'd60, 1'b0, 8'hFF, 4'd8,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd8,   6'd56, 1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b0, '{8'h00, 1'b0}},
        // zero count writes nothing
        '{'{ACT_FIELD,   7'd9,   6'd0,  1'b0, 8'hFF, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd9,   6'd0,  1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        // count above eight saturates
        '{'{ACT_FIELD,   7'd10,  6'd4,  1'b0, 8'hF0, 4'd15, 3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd10,  6'd8,  1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b0, '{8'h00, 1'b0}},
        '{'{ACT_LINE,    7'd3,   6'd63, 1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_READ,    7'd64,  6'd56, 1'b0, 8'h00, 4'd0,  3'd0, 3'd0}, 1'b0, '{8'h00, 1'b0}},
        '{'{ACT_CLEAR,   7'd0,   6'd0,  1'b0, 8'h00, 4'd0,  3'd3, 3'd1}, 1'b1, '{8'h00, 1'b1}},
        '{'{ACT_CLEAR,   7'd0,   6'd0,  1'b0, 8'h00, 4'd0,  3'd0, 3'd7}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_SPARE_5, 7'd5,   6'd0,  1'b1, 8'hFF, 4'd8,  3'd7, 3'd0}, 1'b1, '{8'h00, 1'b0}},
        '{'{ACT_SPARE_7, 7'd127, 6'd63, 1'b1, 8'hFF, 4'd15, 3'd0, 3'd7}, 1'b1, '{8'h00, 1'b0}}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    logic [BYTE_W-1:0] frame_shadow [PAGES][COLS] = '{default: '0};
    logic              inverse_shadow = 1'b0;
    reply_t            pending_replies [$];
    bit                no_gaps = 1'b0;
    int                errors = 0;
    int                replies_checked = 0;
    int                action_tally [8] = '{default: 0};

    page_framebuffer_draw_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_command(input draw_cmd_t c);
        return {5'd0, c.last_page, c.first_page, c.bit_count, c.field_value,
                c.pixel_on, c.pixel_row, c.column, c.action};
    endfunction

    // Applies one command to the frame shadow and returns the reply it produces.
    function automatic reply_t apply_draw_command(input draw_cmd_t c);
        reply_t      r;
        int          pg;
        int          n;
        logic [7:0]  row_bit;
        logic [15:0] mask16;
        logic [15:0] val16;
        r = '0;
        pg = c.pixel_row[5:3];
        row_bit = 8'h01 << c.pixel_row[2:0];
        case (c.action)
            ACT_PIXEL:
            begin
                if (c.pixel_on != inverse_shadow)
                    frame_shadow[pg][c.column] |= row_bit;
                else
                    frame_shadow[pg][c.column] &= ~row_bit;
            end
            ACT_FIELD:
            begin
                n = (c.bit_count > MAX_BIT_COUNT) ? MAX_BIT_COUNT : c.bit_count;
                mask16 = ((16'h0001 << n) - 16'h0001) << c.pixel_row[2:0];
                val16 = ({8'h00, c.field_value} << c.pixel_row[2:0]) & mask16;
                frame_shadow[pg][c.column] =
                    (frame_shadow[pg][c.column] & ~mask16[7:0]) | val16[7:0];
                if (mask16[15:8] != 8'h00 && pg + 1 < PAGES)
                    frame_shadow[pg + 1][c.column] =
                        (frame_shadow[pg + 1][c.column] & ~mask16[15:8]) | val16[15:8];
            end
            ACT_LINE:
            begin
                for (int col = 0; col < COLS; col++)
                    frame_shadow[pg][col] |= row_bit;
            end
            ACT_CLEAR:
            begin
                if (c.last_page < c.first_page)
                    r.range_empty = 1'b1;
                else
                    for (int p = c.first_page; p <= c.last_page && p < PAGES; p++)
                        for (int col = 0; col < COLS; col++)
                            frame_shadow[p][col] = '0;
            end
            ACT_READ:
            begin
                r.read_byte = frame_shadow[pg][c.column];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Coordinates cluster on the edge columns so reads see earlier writes.
    function automatic draw_cmd_t random_command();
        draw_cmd_t c;
        int        sel;
        sel = $urandom_range(0, 99);
        if (sel < 26)
            c.action = ACT_PIXEL;
        else if (sel < 52)
            c.action = ACT_FIELD;
        else if (sel < 82)
            c.action = ACT_READ;
        else if (sel < 88)
            c.action = ACT_LINE;
        else if (sel < 94)
            c.action = ACT_CLEAR;
        else
        begin
            case ($urandom_range(0, 2))
                0:       c.action = ACT_SPARE_5;
                1:       c.action = ACT_SPARE_6;
                default: c.action = ACT_SPARE_7;
            endcase
        end
        if ($urandom_range(0, 9) < 7)
        begin
            c.column = 7'($urandom_range(0, 7));
            if (c.column >= 7'd4)
                c.column = c.column + 7'd120;
        end
        else
            c.column = 7'($urandom_range(0, COLS - 1));
        c.pixel_row   = 6'($urandom_range(0, 63));
        c.pixel_on    = 1'($urandom_range(0, 1));
        c.field_value = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8)
            c.bit_count = 4'($urandom_range(1, 8));
        else
            c.bit_count = 4'($urandom_range(0, 15));
        c.first_page = 3'($urandom_range(0, 7));
        c.last_page  = 3'($urandom_range(0, 7));
        return c;
    endfunction

    task automatic send_command(input draw_cmd_t c, input logic typed, input reply_t want);
        int     gap;
        reply_t predicted;
        gap = gap_length();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_command(c);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = apply_draw_command(c);
        pending_replies.push_back(typed ? want : predicted);
        action_tally[c.action]++;
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_inverse_mode(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INVERSE_MODE, 2'b00};
        pwdata  <= {{(APB_DATA_W-1){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        inverse_shadow = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: ready runs broken by stalls, mostly short.
    initial
    begin
        int run;
        int stall;
        forever
        begin
            m_axis_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            stall = gap_length();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply transfer, tdata=%h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (m_axis_tdata[7:0] !== want.read_byte)
                begin
                    $error("read_byte: expected %h, got %h", want.read_byte, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[8] !== want.range_empty)
                begin
                    $error("range_empty: expected %b, got %b", want.range_empty,
                           m_axis_tdata[8]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_replies();
            write_inverse_mode((phase % 2) == 0);
            no_gaps = (phase == 3);
            repeat (RANDOM_ITEMS / PHASES)
                send_command(random_command(), 1'b0, '0);
        end

        drain_replies();
        repeat (16) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d replies never arrived", pending_replies.size());
            errors++;
        end

        $display("Covered %0d pixel, %0d field, %0d line, %0d clear, %0d read commands", 
                 action_tally[ACT_PIXEL], action_tally[ACT_FIELD], action_tally[ACT_LINE],
                 action_tally[ACT_CLEAR], action_tally[ACT_READ]);
        $display("plus %0d unused codes over %0d inverse-mode phases; %0d replies checked",
                 action_tally[ACT_SPARE_5] + action_tally[ACT_SPARE_6]
                 + action_tally[ACT_SPARE_7], PHASES, replies_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pfde_pkg.sv
src/pfde_ctrl.sv
src/pfde_datapath.sv
src/page_framebuffer_draw_engine_core.sv
tb/sv/testbench.sv
